### hw/rtl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared codes, widths and command/status types of the page-frame pool.
// ----------------------------------------------------------------------------
package pfp_pkg;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 24;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int FIX_W    = 8;
    localparam int STAMP_W  = 16;
    localparam int CNT_W    = 32;
    localparam int OUT_FRAME_W = 4;
    localparam int OUT_PAGE_W  = 24;
    localparam int MAX_RESULTS = 16;

    localparam logic [CMD_W-1:0] CMD_PIN   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNPIN = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DIRTY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FORCE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTPIN   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FIXFULL  = 3'd4;

    localparam logic [FIX_W-1:0] FIX_MAX = 8'hFF;
    localparam logic [STAMP_W-1:0] STAMP_MAX = 16'hFFFF;

    localparam logic [0:0] REG_POLICY = 1'b0;
    localparam logic [0:0] REG_FRAMES = 1'b1;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,      // idle
        OP_CLR,       // clear scan registers, latch the item
        OP_SCAN,      // examine frame at scan index
        OP_MIN_SCAN,  // renormalise: find smallest valid stamp
        OP_MIN_SUB,   // renormalise: subtract from frame at index
        OP_MIN_CLK,   // renormalise: subtract from stamp clock
        OP_APPLY,     // commit the item's update and build result
        OP_FL_STEP    // flush: examine one frame, maybe emit
    } t_op;

    typedef struct packed {
        t_op  op;
        logic idx_rst;   // restart frame index at zero
    } t_cmd;

    typedef struct packed {
        logic idx_end;    // index at last active frame
        logic all_end;    // index at last frame of the table
        logic need_renorm;// stamp clock above limit and a stamp is needed
        logic fl_done;    // flush reached its limit of results
    } t_stat;

endpackage

### hw/rtl/pfp_ctrl.sv
// ----------------------------------------------------------------------------
// pfp_ctrl
// Sequencer: scan, optional stamp renormalisation, apply, and flush walk.
// ----------------------------------------------------------------------------
module pfp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_flush,
    input  logic           i_out_free,
    input  pfp_pkg::t_stat i_stat,
    output pfp_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import pfp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MINS  = 3'd2;
    localparam logic [2:0] S_MINB  = 3'd3;
    localparam logic [2:0] S_MINC  = 3'd4;
    localparam logic [2:0] S_APPLY = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;
    localparam logic [2:0] S_FLEND = 3'd7;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_cmd.idx_rst = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_CLR;
                    o_cmd.idx_rst = 1'b1;
                    n_state = i_flush ? S_FLUSH : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_stat.idx_end) begin
                    o_cmd.idx_rst = 1'b1;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (i_stat.need_renorm) begin
                    o_cmd.idx_rst = 1'b1;
                    n_state = S_MINS;
                end else if (i_out_free) begin
                    o_cmd.op = OP_APPLY;
                    n_state = S_IDLE;
                end
            end
            // renormalisation walks the whole table, in use or not
            S_MINS: begin
                o_cmd.op = OP_MIN_SCAN;
                if (i_stat.all_end) begin
                    o_cmd.idx_rst = 1'b1;
                    n_state = S_MINB;
                end
            end
            S_MINB: begin
                o_cmd.op = OP_MIN_SUB;
                if (i_stat.all_end) begin
                    o_cmd.idx_rst = 1'b1;
                    n_state = S_MINC;
                end
            end
            S_MINC: begin
                o_cmd.op = OP_MIN_CLK;
                n_state = S_APPLY;
            end
            S_FLUSH: begin
                // hold while a flushed result waits for the output slot
                if (i_out_free) begin
                    o_cmd.op = OP_FL_STEP;
                    if (i_stat.idx_end || i_stat.fl_done) begin
                        n_state = S_FLEND;
                    end
                end
            end
            S_FLEND: begin
                if (i_out_free) begin
                    o_cmd.op = OP_APPLY;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### hw/rtl/pfp_dp.sv
// ----------------------------------------------------------------------------
// pfp_dp
// Frame table, scan registers, stamp clock, I/O counters and result builder.
// ----------------------------------------------------------------------------
module pfp_dp #(
    parameter int STAMP_LIMIT = 32000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfp_pkg::t_cmd                 i_cmd,
    input  logic [pfp_pkg::CMD_W-1:0]     i_item_cmd,
    input  logic [pfp_pkg::PAGE_BITS-1:0] i_item_page,
    input  logic                          i_policy,
    input  logic [4:0]                    i_frames_in_use,
    output pfp_pkg::t_stat                o_stat,
    output logic                          o_res_valid,
    output logic [pfp_pkg::STATUS_W-1:0]  o_status,
    output logic [pfp_pkg::OUT_FRAME_W-1:0] o_frame,
    output logic                          o_writeback,
    output logic [pfp_pkg::OUT_PAGE_W-1:0] o_wb_page,
    output logic                          o_load,
    output logic [pfp_pkg::FIX_W-1:0]     o_fix,
    output logic [pfp_pkg::CNT_W-1:0]     o_read_ios,
    output logic [pfp_pkg::CNT_W-1:0]     o_write_ios,
    output logic                          o_last
);
    import pfp_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NW = $clog2(FRAMES + 1);
    localparam int RW = $clog2(MAX_RESULTS + 1);

    logic [PAGE_BITS-1:0] r_page  [FRAMES];
    logic [STAMP_W-1:0]   r_stamp [FRAMES];
    logic [FIX_W-1:0]     r_fix   [FRAMES];
    logic [FRAMES-1:0]    r_valid;
    logic [FRAMES-1:0]    r_dirty;
    logic [STAMP_W-1:0]   r_clk_st;
    logic [CNT_W-1:0]     r_rd, r_wr;

    logic [IW-1:0]        r_idx;
    logic                 r_hit, r_empty, r_vic;
    logic [IW-1:0]        r_hit_i, r_empty_i, r_vic_i;
    logic [STAMP_W-1:0]   r_lo;
    logic [RW-1:0]        r_nres;
    logic                 r_renormed;

    // active frame count: 0 acts as 1, above FRAMES acts as FRAMES
    logic [NW-1:0] w_n;
    always_comb begin
        if (i_frames_in_use == 5'd0) begin
            w_n = NW'(1);
        end else if (32'(i_frames_in_use) > FRAMES) begin
            w_n = NW'(FRAMES);
        end else begin
            w_n = NW'(i_frames_in_use);
        end
    end

    logic w_end;
    assign w_end = (NW'(r_idx) + NW'(1) >= w_n);

    // stamp is needed by a pin that hits under LRU (and not at full count)
    // or by a pin that loads
    logic w_pin, w_stamp_need;
    assign w_pin = (i_item_cmd == CMD_PIN);
    always_comb begin
        if (r_hit) begin
            w_stamp_need = w_pin && i_policy && (r_fix[r_hit_i] != FIX_MAX);
        end else begin
            w_stamp_need = w_pin && (r_empty || r_vic);
        end
    end

    logic w_fl_elig;
    assign w_fl_elig = r_valid[r_idx] && r_dirty[r_idx] && (r_fix[r_idx] == '0);

    // flush: any eligible frame still ahead of the index decides last
    logic [FRAMES-1:0] w_later;
    logic              w_more;
    always_comb begin
        for (int k = 0; k < FRAMES; k++) begin
            w_later[k] = r_valid[k] && r_dirty[k] && (r_fix[k] == '0) &&
                         (NW'(k) < w_n) && (IW'(k) > r_idx);
        end
    end
    assign w_more = |w_later;

    assign o_stat.idx_end     = w_end;
    assign o_stat.all_end     = (r_idx == IW'(FRAMES - 1));
    assign o_stat.need_renorm = w_stamp_need && !r_renormed &&
                                (32'(r_clk_st) > STAMP_LIMIT);
    assign o_stat.fl_done     = w_fl_elig && (r_nres == RW'(MAX_RESULTS - 1));

    logic [STAMP_W-1:0] w_clk_inc;
    assign w_clk_inc = (r_clk_st != STAMP_MAX) ? r_clk_st + 1'b1 : r_clk_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_dirty     <= '0;
            r_clk_st    <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_idx       <= '0;
            r_renormed  <= 1'b0;
            o_res_valid <= 1'b0;
            for (int k = 0; k < FRAMES; k++) begin
                r_fix[k] <= '0;
            end
        end else begin
            o_res_valid <= 1'b0;
            if (i_cmd.idx_rst) begin
                r_idx <= '0;
            end else if (i_cmd.op == OP_SCAN || i_cmd.op == OP_MIN_SCAN ||
                         i_cmd.op == OP_MIN_SUB || i_cmd.op == OP_FL_STEP) begin
                r_idx <= r_idx + 1'b1;
            end
            case (i_cmd.op)
                OP_CLR: begin
                    r_hit  <= 1'b0;
                    r_empty <= 1'b0;
                    r_vic  <= 1'b0;
                    r_nres <= '0;
                    r_renormed <= 1'b0;
                end
                OP_SCAN: begin
                    if (r_valid[r_idx] && r_page[r_idx] == i_item_page && !r_hit) begin
                        r_hit   <= 1'b1;
                        r_hit_i <= r_idx;
                    end
                    if (!r_valid[r_idx] && !r_empty) begin
                        r_empty   <= 1'b1;
                        r_empty_i <= r_idx;
                    end
                    if (r_fix[r_idx] == '0 && (!r_vic || r_stamp[r_idx] <= r_lo)) begin
                        r_vic   <= 1'b1;
                        r_vic_i <= r_idx;
                        r_lo    <= r_stamp[r_idx];
                    end
                end
                OP_MIN_SCAN: begin
                    if (r_idx == '0) begin
                        r_lo <= (r_valid[0] && r_stamp[0] < r_clk_st) ? r_stamp[0]
                                                                       : r_clk_st;
                    end else if (r_valid[r_idx] && r_stamp[r_idx] < r_lo) begin
                        r_lo <= r_stamp[r_idx];
                    end
                end
                OP_MIN_SUB: begin
                    if (r_valid[r_idx]) begin
                        r_stamp[r_idx] <= r_stamp[r_idx] - r_lo;
                    end
                end
                OP_MIN_CLK: begin
                    r_clk_st <= r_clk_st - r_lo;
                    // one renormalisation per stamp taken
                    r_renormed <= 1'b1;
                    // scan stamps changed by the same offset: keep victim order
                    r_lo <= r_lo;
                end
                OP_FL_STEP: begin
                    if (w_fl_elig) begin
                        r_dirty[r_idx] <= 1'b0;
                        r_wr           <= r_wr + 1'b1;
                        r_nres         <= r_nres + 1'b1;
                        o_res_valid    <= 1'b1;
                        o_status       <= ST_OK;
                        o_frame        <= OUT_FRAME_W'(r_idx);
                        o_writeback    <= 1'b1;
                        o_wb_page      <= OUT_PAGE_W'(r_page[r_idx]);
                        o_load         <= 1'b0;
                        o_fix          <= '0;
                        o_read_ios     <= r_rd;
                        o_write_ios    <= r_wr + 1'b1;
                        o_last         <= o_stat.fl_done || !w_more;
                    end
                end
                OP_APPLY: begin
                    o_res_valid <= 1'b1;
                    o_status    <= ST_OK;
                    o_frame     <= '0;
                    o_writeback <= 1'b0;
                    o_wb_page   <= '0;
                    o_load      <= 1'b0;
                    o_fix       <= '0;
                    o_read_ios  <= r_rd;
                    o_write_ios <= r_wr;
                    o_last      <= 1'b1;
                    if (i_item_cmd == CMD_FLUSH) begin
                        // a walk that emitted already closed with last
                        o_res_valid <= (r_nres == '0);
                    end else if (w_pin) begin
                        if (r_hit) begin
                            o_frame <= OUT_FRAME_W'(r_hit_i);
                            if (r_fix[r_hit_i] == FIX_MAX) begin
                                o_status <= ST_FIXFULL;
                                o_fix    <= FIX_MAX;
                            end else begin
                                r_fix[r_hit_i] <= r_fix[r_hit_i] + 1'b1;
                                o_fix <= r_fix[r_hit_i] + 1'b1;
                                if (i_policy) begin
                                    r_stamp[r_hit_i] <= r_clk_st;
                                    r_clk_st <= w_clk_inc;
                                end
                            end
                        end else if (r_empty || r_vic) begin
                            logic [IW-1:0] v;
                            v = r_empty ? r_empty_i : r_vic_i;
                            if (!r_empty && r_dirty[v]) begin
                                o_writeback <= 1'b1;
                                o_wb_page   <= OUT_PAGE_W'(r_page[v]);
                                r_wr        <= r_wr + 1'b1;
                                o_write_ios <= r_wr + 1'b1;
                            end
                            r_valid[v] <= 1'b1;
                            r_page[v]  <= i_item_page;
                            r_dirty[v] <= 1'b0;
                            r_fix[v]   <= FIX_W'(1);
                            r_stamp[v] <= r_clk_st;
                            r_clk_st   <= w_clk_inc;
                            r_rd       <= r_rd + 1'b1;
                            o_read_ios <= r_rd + 1'b1;
                            o_frame    <= OUT_FRAME_W'(v);
                            o_load     <= 1'b1;
                            o_fix      <= FIX_W'(1);
                        end else begin
                            o_status <= ST_NOFREE;
                        end
                    end else if (!r_hit) begin
                        o_status <= ST_NOTFOUND;
                    end else begin
                        o_frame <= OUT_FRAME_W'(r_hit_i);
                        o_fix   <= r_fix[r_hit_i];
                        case (i_item_cmd)
                            CMD_UNPIN: begin
                                if (r_fix[r_hit_i] == '0) begin
                                    o_status <= ST_NOTPIN;
                                end else begin
                                    r_fix[r_hit_i] <= r_fix[r_hit_i] - 1'b1;
                                    o_fix <= r_fix[r_hit_i] - 1'b1;
                                end
                            end
                            CMD_DIRTY: r_dirty[r_hit_i] <= 1'b1;
                            default: begin
                                r_dirty[r_hit_i] <= 1'b0;
                                r_wr        <= r_wr + 1'b1;
                                o_write_ios <= r_wr + 1'b1;
                                o_writeback <= 1'b1;
                                o_wb_page   <= OUT_PAGE_W'(r_page[r_hit_i]);
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### hw/rtl/page_frame_pool_fifo_lru.sv
// Sequence: the item scans the frames in use, one frame per cycle, then applies
//   once the output slot is free; a stamp renormalisation first walks the table
//   for the smallest stamp, walks it again to subtract it, then steps the clock.
// Items: one at a time; a flush emits a result per write-back, holding on stalls.
// Reset: synchronous, active low; clears frame valid/dirty/fix, stamp clock,
//   I/O counters and configuration (policy FIFO, sixteen frames).
// ----------------------------------------------------------------------------
// page_frame_pool_fifo_lru
// Buffer-pool page-frame table with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
module page_frame_pool_fifo_lru #(
    parameter int STAMP_LIMIT = 32000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis tdata: cmd[2:0], page_num[26:3], zero pad [31:27]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    // m_axis tdata: status[2:0], frame[6:3], writeback[7], writeback_page[31:8],
    //   load[32], fix_count[40:33], read_ios[72:41], write_ios[104:73], pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [111:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);
    import pfp_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_busy;

    logic               r_policy;
    logic [4:0]         r_frames;
    logic [CMD_W-1:0]   r_cmd;
    logic [PAGE_BITS-1:0] r_page;

    logic [CMD_W-1:0] w_in_cmd;
    logic             w_known, w_start;

    assign w_in_cmd = s_axis_tdata[2:0];
    // unknown commands are taken and dropped without a result
    assign w_known  = (w_in_cmd == CMD_PIN) || (w_in_cmd == CMD_UNPIN) ||
                      (w_in_cmd == CMD_DIRTY) || (w_in_cmd == CMD_FORCE) ||
                      (w_in_cmd == CMD_FLUSH);
    assign s_axis_tready = !w_busy;
    assign w_start  = s_axis_tvalid && s_axis_tready && w_known;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
            r_frames <= 5'd16;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_POLICY: r_policy <= i_cfg_data[0];
                REG_FRAMES: r_frames <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cmd  <= w_in_cmd;
            r_page <= PAGE_BITS'(s_axis_tdata[26:3]);
        end
    end

    // output register: hold a result until its transfer
    logic                 w_rv, w_wb, w_ld, w_last;
    logic [STATUS_W-1:0]  w_st;
    logic [OUT_FRAME_W-1:0] w_fr;
    logic [OUT_PAGE_W-1:0] w_wbp;
    logic [FIX_W-1:0]     w_fix;
    logic [CNT_W-1:0]     w_rd, w_wr;
    logic                 r_ov;
    logic [104:0]         r_od;
    logic                 r_ol;
    logic                 w_free;

    // slot free for a new result: empty or draining, and none in flight
    assign w_free = (!r_ov || m_axis_tready) && !w_rv;

    pfp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_flush(w_in_cmd == CMD_FLUSH), .i_out_free(w_free),
        .i_stat(w_stat), .o_cmd(w_cmd), .o_busy(w_busy)
    );

    pfp_dp #(.STAMP_LIMIT(STAMP_LIMIT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_item_cmd(r_cmd),
        .i_item_page(r_page), .i_policy(r_policy), .i_frames_in_use(r_frames),
        .o_stat(w_stat), .o_res_valid(w_rv), .o_status(w_st), .o_frame(w_fr),
        .o_writeback(w_wb), .o_wb_page(w_wbp), .o_load(w_ld), .o_fix(w_fix),
        .o_read_ios(w_rd), .o_write_ios(w_wr), .o_last(w_last)
    );

    // datapath result lands in the cycle after its command; slot was free then
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_rv) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rv) begin
            r_od <= {w_wr, w_rd, w_fix, w_ld, w_wbp, w_wb, w_fr, w_st};
            r_ol <= w_last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_od};
    assign m_axis_tlast  = r_ol;

`ifndef ASSERT_OFF
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_start) else $error("item taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
`endif

endmodule
